>>> rtl/dmts_pkg.sv
// ----------------------------------------------------------------------------
// dmts_pkg: shared types and constants
// parse phases, option codes and the result word layout for the scanner
// ----------------------------------------------------------------------------
package dmts_pkg;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DRAIN = 2'd3
  } phase_t;

  localparam logic [7:0] OPT_PAD      = 8'h00;
  localparam logic [7:0] OPT_END      = 8'hFF;
  localparam logic [7:0] OPT_TYPE     = 8'd53;
  localparam logic [7:0] UNKNOWN_TYPE = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] message_type;
    logic       found;
  } result_t;

endpackage

>>> rtl/dhcp_message_type_option_scan_unit.sv
// ----------------------------------------------------------------------------
// dhcp_message_type_option_scan_unit: dhcp message type scanner
// walks the options area one byte per word and reports option 53
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready carry data_byte and last_byte, one byte
//   of the dhcp options area per word, last_byte set on the packet's final byte
//   output channel: out_valid / out_ready carry message_type and found
//   each packet gives exactly one result word: the first value byte of a
//   complete option 53 ending before last_byte with found set, or 0xff with found
//   clear at end option or packet end; bytes after a result drop up to last_byte
// timing
//   an accepted byte is held in the input register, then the walker
//   updates its phase and, when a result is due, loads the result register:
//   a result is offered once its byte has passed the input and result registers
//   one byte per cycle sustained while no result waits untaken; the walker's
//   phase update sits between the input and result registers
// reset and stall
//   rst (synchronous) returns the walker to expecting an option code and
//   empties both registers
//   while a result waits untaken, the held byte waits too and in_ready drops
//   once the input register is full; no word is lost or repeated
// ----------------------------------------------------------------------------
module dhcp_message_type_option_scan_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] message_type,
  output logic       found
);
  import dmts_pkg::*;

  in_word_t in_word;
  in_word_t hold_word;
  logic     hold_valid;
  logic     advance;
  logic     emit;
  logic     load;
  result_t  result;

  assign in_word.data_byte = data_byte;
  assign in_word.last_byte = last_byte;

  // the held byte moves on only when the result slot is free or draining
  assign advance = hold_valid && (!out_valid || out_ready);
  assign load    = advance && emit;

  dmts_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_word  (hold_word)
  );

  dmts_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (hold_word),
    .emit    (emit),
    .result  (result)
  );

  dmts_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .result       (result),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .message_type (message_type),
    .found        (found)
  );

  // a stalled result never gets overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(load && out_valid && !out_ready))
    else $error("result overwritten while stalled");

  // an accepted byte always lands in the input register
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> hold_valid)
    else $error("accepted byte not held");

  // in_ready only drops while a byte is held
  a_ready_low_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> hold_valid)
    else $error("in_ready low with empty input register");

  // a loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not offered");

  // a found result never comes from the packet's final byte
  a_found_not_last: assert property (@(posedge clk) disable iff (rst)
    (load && result.found) |-> !hold_word.last_byte)
    else $error("found result on final byte");

endmodule

>>> rtl/dmts_in_reg.sv
// ----------------------------------------------------------------------------
// dmts_in_reg: input register
// holds one accepted word until the parse stage consumes it
// ----------------------------------------------------------------------------
module dmts_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dmts_pkg::in_word_t in_word,
  input  logic               advance,
  output logic               hold_valid,
  output dmts_pkg::in_word_t hold_word
);
  import dmts_pkg::*;

  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_word <= in_word;
    end
  end

endmodule

>>> rtl/dmts_step.sv
// ----------------------------------------------------------------------------
// dmts_step: option walker
// per-byte phase update and result decision for the options area
// ----------------------------------------------------------------------------
module dmts_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  dmts_pkg::in_word_t word,
  output logic               emit,
  output dmts_pkg::result_t  result
);
  import dmts_pkg::*;

  phase_t     parse_phase, parse_phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       is_type_option, is_type_option_next;
  logic       first_value_pending, first_value_pending_next;
  logic [7:0] captured_value, captured_value_next;
  logic [7:0] value_now;
  logic [7:0] left_dec;
  logic [7:0] b;
  logic       last;

  assign b    = word.data_byte;
  assign last = word.last_byte;
  assign value_now = first_value_pending ? b : captured_value;
  assign left_dec  = bytes_left - 8'd1;

  always_comb begin
    parse_phase_next         = parse_phase;
    bytes_left_next          = bytes_left;
    is_type_option_next      = is_type_option;
    first_value_pending_next = first_value_pending;
    captured_value_next      = captured_value;
    emit                     = 1'b0;
    result.message_type      = UNKNOWN_TYPE;
    result.found             = 1'b0;
    unique case (parse_phase)
      PH_CODE: begin
        if (b == OPT_END) begin
          emit = 1'b1;
          parse_phase_next = last ? PH_CODE : PH_DRAIN;
        end else if (last) begin
          // option cut short by packet end
          emit = 1'b1;
          parse_phase_next = PH_CODE;
        end else if (b != OPT_PAD) begin
          is_type_option_next = (b == OPT_TYPE);
          parse_phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (last) begin
          emit = 1'b1;
          parse_phase_next = PH_CODE;
        end else if (b == 8'd0) begin
          // zero-length option skipped
          parse_phase_next = PH_CODE;
        end else begin
          bytes_left_next = b;
          first_value_pending_next = 1'b1;
          parse_phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (first_value_pending) begin
          captured_value_next = b;
          first_value_pending_next = 1'b0;
        end
        if (last) begin
          emit = 1'b1;
          parse_phase_next = PH_CODE;
        end else begin
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            if (is_type_option) begin
              emit = 1'b1;
              result.message_type = value_now;
              result.found = 1'b1;
              parse_phase_next = PH_DRAIN;
            end else begin
              parse_phase_next = PH_CODE;
            end
          end
        end
      end
      PH_DRAIN: begin
        if (last) begin
          parse_phase_next = PH_CODE;
        end
      end
      default: begin
        parse_phase_next = PH_CODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PH_CODE;
      bytes_left          <= 8'd0;
      is_type_option      <= 1'b0;
      first_value_pending <= 1'b0;
      captured_value      <= 8'd0;
    end else if (advance) begin
      parse_phase         <= parse_phase_next;
      bytes_left          <= bytes_left_next;
      is_type_option      <= is_type_option_next;
      first_value_pending <= first_value_pending_next;
      captured_value      <= captured_value_next;
    end
  end

endmodule

>>> rtl/dmts_out_reg.sv
// ----------------------------------------------------------------------------
// dmts_out_reg: result register
// holds one result word until the receiver takes it
// ----------------------------------------------------------------------------
module dmts_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dmts_pkg::result_t result,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        message_type,
  output logic              found
);
  import dmts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      message_type <= result.message_type;
      found        <= result.found;
    end
  end

endmodule
